// ===== hw/rtl/imm_dp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package imm_dp_pkg;

  localparam int DEF_MAX_A_LEN = 1024;
  localparam int DEF_MAX_B_LEN = 1024;
  localparam int COST_W        = 12;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef struct packed {
    logic [7:0] a_byte;
    logic       a_present;
    logic [7:0] b_byte;
    logic       b_present;
    logic [7:0] c_byte;
    logic       c_present;
    logic       final_item;
  } imm_req_t;

  typedef struct packed {
    logic [COST_W-1:0] min_changes;
    logic              length_mismatch;
    logic              capacity_overflow;
  } imm_res_t;

  // saturating add of a mismatch bit
  function automatic logic [COST_W-1:0] sat_inc(input logic [COST_W-1:0] v, input logic inc);
    logic [COST_W-1:0] r;
    r = v;
    if (inc && (v != COST_MAX)) begin
      r = v + COST_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/interleave_min_mismatch_dp.sv =====
// a request without final_item gives no result; loading runs at one per cycle while busy is low
// a final request without a length mismatch computes its result one cost-row cell per cycle
// through the cost memory, and busy is high until the result strobe
// a final request with a length mismatch gives its result the next cycle, busy stays low
// results are shown for one cycle and cannot be stalled
// reset clears counters, flags and control; byte and cost memories are not cleared
`timescale 1ns / 1ps
`default_nettype none

module interleave_min_mismatch_dp
  import imm_dp_pkg::*;
#(
  parameter int MAX_A_LEN = DEF_MAX_A_LEN,
  parameter int MAX_B_LEN = DEF_MAX_B_LEN
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire imm_req_t in_data,
  output logic          out_valid,
  output imm_res_t      out_res
);

  localparam int MAX_C_LEN = MAX_A_LEN + MAX_B_LEN;
  localparam int A_AW = (MAX_A_LEN > 1) ? $clog2(MAX_A_LEN) : 1;
  localparam int B_AW = (MAX_B_LEN > 1) ? $clog2(MAX_B_LEN) : 1;
  localparam int C_AW = $clog2(MAX_C_LEN);
  localparam int A_CW = $clog2(MAX_A_LEN + 1);
  localparam int B_CW = $clog2(MAX_B_LEN + 1);
  localparam int C_CW = $clog2(MAX_C_LEN + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

  logic [7:0]        a_mem [MAX_A_LEN];
  logic [7:0]        b_mem [MAX_B_LEN];
  logic [7:0]        c_mem [MAX_C_LEN];
  logic [COST_W-1:0] cost_mem [MAX_B_LEN + 1];

  state_t            state_r;
  logic [A_CW-1:0]   count_a_r;
  logic [B_CW-1:0]   count_b_r;
  logic [C_CW-1:0]   count_c_r;
  logic              ovf_r;
  logic [A_CW-1:0]   ix_r;
  logic [B_CW-1:0]   iy_r;
  logic              p_valid_r;
  logic              p_last_r;
  logic              px_nz_r;
  logic              py_nz_r;
  logic [B_CW-1:0]   py_r;
  logic              fwd_r;
  logic [COST_W-1:0] fwd_val_r;
  logic [COST_W-1:0] left_r;
  logic [7:0]        a_rd_r;
  logic [7:0]        b_rd_r;
  logic [7:0]        c_rd_r;
  logic [COST_W-1:0] cost_rd_r;
  logic              out_valid_r;
  imm_res_t          out_res_r;

  logic              accept;
  logic              a_we;
  logic              b_we;
  logic              c_we;
  logic [A_CW-1:0]   count_a_nxt;
  logic [B_CW-1:0]   count_b_nxt;
  logic [C_CW-1:0]   count_c_nxt;
  logic              ovf_nxt;
  logic              mismatch;
  logic [A_CW-1:0]   a_sum;
  logic [B_CW-1:0]   b_sum;
  logic [C_CW-1:0]   c_sum;
  logic              row_end;
  logic              issue_last;
  logic              issue;
  logic [COST_W-1:0] up_src;
  logic [COST_W-1:0] up_val;
  logic [COST_W-1:0] left_val;
  logic [COST_W-1:0] cell_val;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  assign a_we = accept && in_data.a_present && (count_a_r < A_CW'(MAX_A_LEN));
  assign b_we = accept && in_data.b_present && (count_b_r < B_CW'(MAX_B_LEN));
  assign c_we = accept && in_data.c_present && (count_c_r < C_CW'(MAX_C_LEN));

  assign count_a_nxt = a_we ? count_a_r + A_CW'(1) : count_a_r;
  assign count_b_nxt = b_we ? count_b_r + B_CW'(1) : count_b_r;
  assign count_c_nxt = c_we ? count_c_r + C_CW'(1) : count_c_r;
  assign ovf_nxt = ovf_r || (accept && ((in_data.a_present && !a_we) ||
                   (in_data.b_present && !b_we) || (in_data.c_present && !c_we)));
  assign mismatch = (C_CW'(count_a_nxt) + C_CW'(count_b_nxt)) != count_c_nxt;

  // read addresses of the cell being issued; the origin's c address is unused
  assign a_sum = ix_r - A_CW'(1);
  assign b_sum = iy_r - B_CW'(1);
  assign c_sum = C_CW'(ix_r) + C_CW'(iy_r) - C_CW'(1);

  assign issue      = (state_r == ST_RUN);
  assign row_end    = (iy_r == count_b_r);
  assign issue_last = row_end && (ix_r == count_a_r);

  assign up_src   = fwd_r ? fwd_val_r : cost_rd_r;
  assign up_val   = sat_inc(up_src, c_rd_r != a_rd_r);
  assign left_val = sat_inc(left_r, c_rd_r != b_rd_r);

  always_comb begin
    priority if (!px_nz_r && !py_nz_r) begin
      cell_val = '0;
    end else if (!px_nz_r) begin
      cell_val = left_val;
    end else if (!py_nz_r) begin
      cell_val = up_val;
    end else begin
      cell_val = (up_val < left_val) ? up_val : left_val;
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[count_a_r[A_AW-1:0]] <= in_data.a_byte;
    end
    a_rd_r <= a_mem[a_sum[A_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[count_b_r[B_AW-1:0]] <= in_data.b_byte;
    end
    b_rd_r <= b_mem[b_sum[B_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[count_c_r[C_AW-1:0]] <= in_data.c_byte;
    end
    c_rd_r <= c_mem[c_sum[C_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (p_valid_r) begin
      cost_mem[py_r] <= cell_val;
    end
    cost_rd_r <= cost_mem[iy_r];
  end

  // cell datapath registers
  always_ff @(posedge clk) begin
    if (p_valid_r) begin
      left_r <= cell_val;
    end
    fwd_val_r <= cell_val;
    px_nz_r   <= (ix_r != '0);
    py_nz_r   <= (iy_r != '0);
    py_r      <= iy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_a_r   <= '0;
      count_b_r   <= '0;
      count_c_r   <= '0;
      ovf_r       <= 1'b0;
      ix_r        <= '0;
      iy_r        <= '0;
      p_valid_r   <= 1'b0;
      p_last_r    <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_res_r   <= '0;
    end else begin
      out_valid_r <= 1'b0;
      p_valid_r   <= issue;
      p_last_r    <= issue && issue_last;
      // write-back of the cell in flight lands on the entry being read
      fwd_r       <= issue && p_valid_r && (py_r == iy_r);
      unique case (state_r)
        ST_IDLE: begin
          ix_r <= '0;
          iy_r <= '0;
          if (accept) begin
            count_a_r <= count_a_nxt;
            count_b_r <= count_b_nxt;
            count_c_r <= count_c_nxt;
            ovf_r     <= ovf_nxt;
            if (in_data.final_item) begin
              if (mismatch) begin
                out_valid_r                 <= 1'b1;
                out_res_r.min_changes       <= '0;
                out_res_r.length_mismatch   <= 1'b1;
                out_res_r.capacity_overflow <= ovf_nxt;
                count_a_r <= '0;
                count_b_r <= '0;
                count_c_r <= '0;
                ovf_r     <= 1'b0;
              end else begin
                state_r <= ST_RUN;
              end
            end
          end
        end
        ST_RUN: begin
          if (row_end) begin
            iy_r <= '0;
            if (issue_last) begin
              state_r <= ST_DRAIN;
            end else begin
              ix_r <= ix_r + A_CW'(1);
            end
          end else begin
            iy_r <= iy_r + B_CW'(1);
          end
        end
        ST_DRAIN: begin
          if (p_valid_r && p_last_r) begin
            state_r                     <= ST_IDLE;
            out_valid_r                 <= 1'b1;
            out_res_r.min_changes       <= cell_val;
            out_res_r.length_mismatch   <= 1'b0;
            out_res_r.capacity_overflow <= ovf_r;
            count_a_r <= '0;
            count_b_r <= '0;
            count_c_r <= '0;
            ovf_r     <= 1'b0;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r |-> (state_r != ST_IDLE))
    else $error("cell in flight while idle");

  a_counts_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (count_a_r == '0 && count_b_r == '0 && count_c_r == '0 && !ovf_r))
    else $error("counters not cleared after result");

  a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (ix_r <= count_a_r && iy_r <= count_b_r))
    else $error("cell index beyond string length");

  a_mismatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.length_mismatch) |-> (out_res_r.min_changes == '0))
    else $error("nonzero cost on length mismatch");

  a_fwd_stage: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> p_valid_r)
    else $error("forwarding without a cell in the stage");

endmodule

`default_nettype wire
